@@ src/sbda_pkg.sv @@
// Shared types and constants for the signed binary to decimal ASCII unit.
`timescale 1ns / 1ps
`default_nettype none

package sbda_pkg;

    // Decimal digit positions examined; the magnitude saturates to all nines above this.
    localparam int MAX_DIGITS = 10;

    localparam int VALUE_W    = 32;
    localparam int MAG_W      = 32;
    localparam int CHAR_W     = 6;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = MAX_DIGITS * DIGIT_W;
    localparam int IDX_W      = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam int CMP_W      = 64;

    // Double-dabble split: DD_STEPS shift steps per pipeline stage.
    localparam int DD_STEPS   = 8;
    localparam int DD_STAGES  = MAG_W / DD_STEPS;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO  = CHAR_W'(48);
    localparam logic [CHAR_W-1:0]  CHAR_MINUS = CHAR_W'(45);
    localparam logic [DIGIT_W-1:0] DIGIT_MAX  = DIGIT_W'(9);

    function automatic logic [CMP_W-1:0] pow10(input int n);
        logic [CMP_W-1:0] p;
        p = CMP_W'(1);
        for (int k = 0; k < n; k++) begin
            p = p * CMP_W'(10);
        end
        return p;
    endfunction

    // Largest magnitude that fits in MAX_DIGITS decimal digits.
    localparam logic [CMP_W-1:0] MAX_MAG = pow10(MAX_DIGITS) - CMP_W'(1);

    typedef logic [DIGIT_W-1:0] t_digit;

    // Double-dabble working word: BCD accumulator and remaining binary bits.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
        logic [MAG_W-1:0] bin;
    } t_dd;

    // Finished conversion handed to the serializer.
    typedef struct packed {
        logic             neg;
        logic [BCD_W-1:0] bcd;
    } t_digits;

endpackage

`default_nettype wire

@@ src/signed_binary_to_decimal_ascii_unit.sv @@
// Top level: signed 32-bit number to decimal ASCII character stream.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+---------------------------
//  input   | in        | i_valid / o_stall  | i_value (signed 32)
//  output  | out       | o_valid / i_stall  | o_ascii_char (6), o_last
//
// A transfer takes place on a rising edge with valid high and stall low.
// Each number yields 1 to 11 character transfers, one per cycle while i_stall
// stays low; the serializer feeding the output register sets that rate, and
// it loads the next number in the cycle its last character leaves, without a
// bubble.
// From input transfer to first character a number passes the input register,
// sign/saturation register, four 8-step double-dabble stages, serializer and
// output register.
// Reset is synchronous, active low, and clears every valid flag.
// Output stall backs up through the stages; o_stall rises only when every
// stage holds a number.
`timescale 1ns / 1ps
`default_nettype none

module signed_binary_to_decimal_ascii_unit (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic signed [sbda_pkg::VALUE_W-1:0] i_value,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [sbda_pkg::CHAR_W-1:0]              o_ascii_char,
    output logic                                     o_last
);
    import sbda_pkg::*;

    // Stage k hands to stage k+1; index 0 is the prep stage output.
    logic    vld   [DD_STAGES+1];
    logic    rdy   [DD_STAGES+1];
    t_dd     item  [DD_STAGES+1];

    logic    prep_ready;
    t_digits ser_item;

    sbda_prep u_prep (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (prep_ready),
        .i_value (i_value),
        .o_valid (vld[0]),
        .i_ready (rdy[0]),
        .o_item  (item[0])
    );

    assign o_stall = !prep_ready;

    for (genvar g = 0; g < DD_STAGES; g++) begin : g_dabble
        sbda_dabble_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (vld[g]),
            .o_ready (rdy[g]),
            .i_item  (item[g]),
            .o_valid (vld[g+1]),
            .i_ready (rdy[g+1]),
            .o_item  (item[g+1])
        );
    end

    // After all shift steps the binary part is spent; only sign and BCD go on.
    assign ser_item.neg = item[DD_STAGES].neg;
    assign ser_item.bcd = item[DD_STAGES].bcd;

    sbda_serializer u_ser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (vld[DD_STAGES]),
        .o_ready      (rdy[DD_STAGES]),
        .i_item       (ser_item),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    a_bin_spent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        vld[DD_STAGES] |-> (item[DD_STAGES].bin == '0))
        else $error("top: binary bits left after conversion");

endmodule

`default_nettype wire

@@ src/sbda_prep.sv @@
// Input register, sign split and magnitude saturation stage.
`timescale 1ns / 1ps
`default_nettype none

module sbda_prep (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_ready,
    input  wire logic signed [sbda_pkg::VALUE_W-1:0] i_value,
    output logic                                    o_valid,
    input  wire logic                               i_ready,
    output sbda_pkg::t_dd                           o_item
);
    import sbda_pkg::*;

    logic                  r_in_vld;
    logic [VALUE_W-1:0]    r_value;
    logic                  r_vld;
    t_dd                   r_item;
    t_dd                   n_item;

    logic                  stage_ready;
    logic                  neg;
    logic [MAG_W-1:0]      mag;

    assign stage_ready = !r_vld || i_ready;
    assign o_ready     = !r_in_vld || stage_ready;

    always_comb begin
        neg = r_value[VALUE_W-1];
        mag = neg ? (~r_value[MAG_W-1:0] + MAG_W'(1)) : r_value[MAG_W-1:0];
        n_item.neg = neg;
        n_item.bcd = '0;
        if ({{(CMP_W-MAG_W){1'b0}}, mag} > MAX_MAG) begin
            n_item.bin = MAX_MAG[MAG_W-1:0];
        end else begin
            n_item.bin = mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
            r_vld    <= 1'b0;
        end else begin
            if (o_ready) begin
                r_in_vld <= i_valid;
            end
            if (stage_ready) begin
                r_vld <= r_in_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_value <= i_value;
        end
        if (r_in_vld && stage_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> ({{(CMP_W-MAG_W){1'b0}}, r_item.bin} <= MAX_MAG))
        else $error("prep: magnitude above saturation limit");

    a_bcd_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> (r_item.bcd == '0))
        else $error("prep: accumulator not cleared");

endmodule

`default_nettype wire

@@ src/sbda_dabble_stage.sv @@
// One pipeline stage of shift-and-add-3 binary to BCD conversion.
`timescale 1ns / 1ps
`default_nettype none

module sbda_dabble_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  sbda_pkg::t_dd      i_item,
    output logic               o_valid,
    input  wire logic          i_ready,
    output sbda_pkg::t_dd      o_item
);
    import sbda_pkg::*;

    logic r_vld;
    t_dd  r_item;
    t_dd  n_item;

    function automatic t_dd dd_step(input t_dd a);
        t_dd              r;
        logic [BCD_W-1:0] adj;
        adj = a.bcd;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (adj[d*DIGIT_W +: DIGIT_W] >= DIGIT_W'(5)) begin
                adj[d*DIGIT_W +: DIGIT_W] = adj[d*DIGIT_W +: DIGIT_W] + DIGIT_W'(3);
            end
        end
        r.neg = a.neg;
        {r.bcd, r.bin} = {adj, a.bin} << 1;
        return r;
    endfunction

    function automatic logic digits_ok(input logic [BCD_W-1:0] b);
        logic ok;
        ok = 1'b1;
        for (int d = 0; d < MAX_DIGITS; d++) begin
            if (b[d*DIGIT_W +: DIGIT_W] > DIGIT_MAX) begin
                ok = 1'b0;
            end
        end
        return ok;
    endfunction

    always_comb begin
        n_item = i_item;
        for (int s = 0; s < DD_STEPS; s++) begin
            n_item = dd_step(n_item);
        end
    end

    assign o_ready = !r_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_vld;
    assign o_item  = r_item;

    a_bcd_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld |-> digits_ok(r_item.bcd))
        else $error("dabble: BCD digit out of range");

endmodule

`default_nettype wire

@@ src/sbda_serializer.sv @@
// Character serializer with output register: sign, then digits without leading zeros.
`timescale 1ns / 1ps
`default_nettype none

module sbda_serializer (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  sbda_pkg::t_digits                  i_item,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [sbda_pkg::CHAR_W-1:0]        o_ascii_char,
    output logic                               o_last
);
    import sbda_pkg::*;

    logic               r_ser_vld;
    logic               r_sign_pend;
    logic [IDX_W-1:0]   r_idx;
    t_digit             r_digits [MAX_DIGITS];

    logic               r_out_vld;
    logic [CHAR_W-1:0]  r_out_char;
    logic               r_out_last;

    logic               out_take;
    logic               ser_fire;
    logic               ser_done;
    logic               load;
    logic [CHAR_W-1:0]  cur_char;
    logic               cur_last;
    logic [IDX_W-1:0]   start_idx;

    // Highest nonzero digit; zero starts at the units digit.
    always_comb begin
        start_idx = '0;
        for (int i = 0; i < MAX_DIGITS; i++) begin
            if (i_item.bcd[i*DIGIT_W +: DIGIT_W] != '0) begin
                start_idx = IDX_W'(i);
            end
        end
    end

    always_comb begin
        if (r_sign_pend) begin
            cur_char = CHAR_MINUS;
            cur_last = 1'b0;
        end else begin
            cur_char = CHAR_ZERO + CHAR_W'(r_digits[r_idx]);
            cur_last = (r_idx == '0);
        end
    end

    assign out_take = !r_out_vld || !i_stall;
    assign ser_fire = r_ser_vld && out_take;
    assign ser_done = ser_fire && cur_last;
    assign o_ready  = !r_ser_vld || ser_done;
    assign load     = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ser_vld   <= 1'b0;
            r_sign_pend <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            if (load) begin
                r_ser_vld   <= 1'b1;
                r_sign_pend <= i_item.neg;
            end else begin
                if (ser_done) begin
                    r_ser_vld <= 1'b0;
                end
                if (ser_fire) begin
                    r_sign_pend <= 1'b0;
                end
            end
            if (out_take) begin
                r_out_vld <= r_ser_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_idx <= start_idx;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                r_digits[i] <= i_item.bcd[i*DIGIT_W +: DIGIT_W];
            end
        end else if (ser_fire && !r_sign_pend) begin
            r_idx <= r_idx - IDX_W'(1);
        end
        if (out_take) begin
            r_out_char <= cur_char;
            r_out_last <= cur_last;
        end
    end

    assign o_valid      = r_out_vld;
    assign o_ascii_char = r_out_char;
    assign o_last       = r_out_last;

    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> (r_out_char == CHAR_MINUS ||
                       (r_out_char >= CHAR_ZERO && r_out_char <= CHAR_ZERO + CHAR_W'(9))))
        else $error("serializer: character outside '-' and digits");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && r_out_char == CHAR_MINUS) |-> !r_out_last)
        else $error("serializer: minus sign marked last");

    a_sign_needs_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sign_pend |-> r_ser_vld)
        else $error("serializer: sign pending without an item");

endmodule

`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the signed binary to decimal ASCII unit: self-checking, randomized traffic.
`timescale 1ns / 1ps

module tb;

    import sbda_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 300000;
    // Settle time after draining, with ample slack over the pipeline depth.
    localparam int          SETTLE_CYCLES = 30;
    localparam int          RANDOM_ITEMS  = 106;

    typedef struct {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } t_char;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_RUNS
    } t_stall_mode;

    // Holds the characters each accepted number must produce, in order.
    class text_scoreboard;
        t_char exp_q[$];
        int    errors;

        function new();
            errors = 0;
        endfunction

        // Render one accepted number as its expected decimal text.
        function void note_value(logic [VALUE_W-1:0] raw);
            t_char      line_q[$];
            t_char      c;
            logic       neg;
            logic       started;
            logic [63:0] mag;
            logic [63:0] top;
            logic [63:0] place;
            logic [63:0] d;
            neg     = raw[VALUE_W-1];
            mag     = {32'd0, neg ? (~raw + 32'd1) : raw};
            started = 1'b0;
            if (mag == 64'd0) begin
                c.ch   = CHAR_ZERO;
                c.last = 1'b1;
                exp_q.push_back(c);
                return;
            end
            if (neg) begin
                c.ch   = CHAR_MINUS;
                c.last = 1'b0;
                line_q.push_back(c);
            end
            top = 64'd1;
            for (int i = 1; i < MAX_DIGITS; i++) begin
                top = top * 64'd10;
            end
            // Too wide for the digit positions: clamp to all nines.
            if (mag / top >= 64'd10) begin
                mag = top * 64'd10 - 64'd1;
            end
            place = top;
            for (int i = 0; i < MAX_DIGITS; i++) begin
                d = mag / place;
                if (d != 64'd0 || started) begin
                    started = 1'b1;
                    c.ch    = CHAR_ZERO + CHAR_W'(d);
                    c.last  = 1'b0;
                    line_q.push_back(c);
                end
                mag   = mag % place;
                place = place / 64'd10;
                if (place == 64'd0) begin
                    place = 64'd1;
                end
            end
            line_q[line_q.size()-1].last = 1'b1;
            foreach (line_q[k]) begin
                exp_q.push_back(line_q[k]);
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            t_char e;
            if (exp_q.size() == 0) begin
                $error("unexpected character: ascii_char %0d, last %0d", ch, last);
                errors++;
                return;
            end
            e = exp_q.pop_front();
            if (ch !== e.ch) begin
                $error("ascii_char mismatch: expected %0d, actual %0d", e.ch, ch);
                errors++;
            end
            if (last !== e.last) begin
                $error("last mismatch: expected %0d, actual %0d", e.last, last);
                errors++;
            end
        endfunction

        function int pending();
            return exp_q.size();
        endfunction
    endclass

    logic                      i_clk   = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_stall;
    logic signed [VALUE_W-1:0] i_value = '0;
    logic                      o_valid;
    logic                      i_stall = 1'b0;
    logic [CHAR_W-1:0]         o_ascii_char;
    logic                      o_last;

    text_scoreboard sb = new();
    int unsigned    cycle_count = 0;

    signed_binary_to_decimal_ascii_unit u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_value      (i_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_ascii_char (o_ascii_char),
        .o_last       (o_last)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** signed_binary_to_decimal_ascii_unit: FAILED **");
            $finish;
        end
    end

    // Output side: check every character transfer, then pick the next stall level.
    t_stall_mode stall_mode = STALL_NONE;
    int          mode_left  = 0;
    int          run_left   = 0;
    logic        run_level  = 1'b0;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            sb.check_char(o_ascii_char, o_last);
        end
        if (mode_left == 0) begin
            stall_mode = t_stall_mode'($urandom_range(0, 3));
            mode_left  = $urandom_range(40, 300);
        end
        mode_left--;
        case (stall_mode)
            STALL_NONE:  i_stall <= 1'b0;
            STALL_LIGHT: i_stall <= ($urandom_range(0, 99) < 25);
            STALL_HEAVY: i_stall <= ($urandom_range(0, 99) < 75);
            default: begin
                if (run_left == 0) begin
                    run_level = ~run_level;
                    run_left  = $urandom_range(1, 16);
                end
                run_left--;
                i_stall <= run_level;
            end
        endcase
    end

    // Present one number and hold it until the unit takes it.
    task automatic send_value(logic [VALUE_W-1:0] v);
        i_valid <= 1'b1;
        i_value <= v;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        sb.note_value(v);
    endtask

    task automatic pause_sender(int n);
        i_valid <= 1'b0;
        i_value <= $urandom;
        repeat (n) @(posedge i_clk);
    endtask

    // Hold off until every expected character has come out, then let the pipe settle.
    task automatic wait_for_drain();
        i_valid <= 1'b0;
        while (sb.pending() > 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [VALUE_W-1:0] random_value();
        logic [63:0] p;
        logic [63:0] m;
        int          k;
        p = 64'd1;
        case ($urandom_range(0, 4))
            0: m = 64'($urandom);
            1: begin
                // Uniform digit count, so short texts are as common as long ones.
                k = $urandom_range(1, 10);
                repeat (k) p = p * 64'd10;
                m = {$urandom, $urandom} % p;
                if (m > 64'h7FFF_FFFF) m = 64'h7FFF_FFFF;
                if ($urandom_range(0, 1)) m = -m;
            end
            2: begin
                k = $urandom_range(0, 9);
                repeat (k) p = p * 64'd10;
                m = p + 64'($urandom_range(0, 2)) - 64'd1;
                if ($urandom_range(0, 1)) m = -m;
            end
            3: m = 64'($urandom_range(0, 40)) - 64'd20;
            default: begin
                if ($urandom_range(0, 1)) begin
                    m = 64'h7FFF_FFFF - 64'($urandom_range(0, 3));
                end else begin
                    m = 64'h8000_0000 + 64'($urandom_range(0, 3));
                end
            end
        endcase
        return m[VALUE_W-1:0];
    endfunction

    logic [VALUE_W-1:0] directed_q[$];
    int                 burst_left;

    initial begin
        directed_q = '{
            32'd0, 32'd1, -32'sd1, 32'd9, 32'd10, -32'sd10, 32'd99, 32'd100,
            -32'sd5, 32'd7, 32'd123456789, 32'd999999999, -32'sd999999999,
            32'd1000000000, 32'd1000000001, -32'sd1000000000, 32'd2000000000,
            32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001, 32'h5555_5555,
            32'hAAAA_AAAA, 32'd1999999999, 32'd0
        };

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero, digit-count boundaries, most negative and most positive.
        foreach (directed_q[n]) begin
            send_value(directed_q[n]);
            if ($urandom_range(0, 3) == 0) begin
                pause_sender($urandom_range(1, 4));
            end
        end
        wait_for_drain();

        burst_left = $urandom_range(1, 20);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == RANDOM_ITEMS / 2) begin
                wait_for_drain();
            end
            send_value(random_value());
            burst_left--;
            if (burst_left == 0) begin
                pause_sender($urandom_range(1, 12));
                burst_left = $urandom_range(1, 20);
            end
        end
        wait_for_drain();

        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("** signed_binary_to_decimal_ascii_unit: PASSED **");
        end else begin
            $display("** signed_binary_to_decimal_ascii_unit: FAILED **");
        end
        $finish;
    end

endmodule
